// File: design/rrf_pkg.sv
// rrf_pkg: types, codes and constants shared by the reply framer modules.
// No dependencies.
package rrf_pkg;

    localparam int NEST_DEPTH_DEF = 8;
    localparam int QUEUE_DEPTH    = 2;

    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    localparam logic [32:0] NUM_SAT = 33'h1_0000_0000;

    typedef enum logic [2:0] {
        KIND_STRING  = 3'd0,
        KIND_ERROR   = 3'd1,
        KIND_INTEGER = 3'd2,
        KIND_BULK    = 3'd3,
        KIND_ARRAY   = 3'd4
    } kind_t;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_PROTOCOL   = 3'd1,
        ST_TOO_LARGE  = 3'd2,
        ST_NEST_OVER  = 3'd3,
        ST_INCOMPLETE = 3'd4
    } status_t;

    typedef enum logic [3:0] {
        PH_IDLE, PH_LINE, PH_LINE_LF, PH_BNUM_FIRST, PH_BNUM, PH_BNUM_LF,
        PH_ANUM_FIRST, PH_ANUM, PH_ANUM_LF, PH_PAYLOAD, PH_PAY_CR, PH_PAY_LF
    } phase_t;

    typedef enum logic {
        CFG_MAX_BULK  = 1'b0,
        CFG_MAX_ARRAY = 1'b1
    } cfg_index_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_available;
    } in_t;

    typedef struct packed {
        logic        frame_end;
        logic [2:0]  reply_kind;
        logic [31:0] reply_bytes;
        logic [2:0]  status;
    } out_t;

    // Classified byte as handed from the front to the back.
    typedef struct packed {
        logic [7:0] data_byte;
        logic       last;
        logic       kind_valid;
        kind_t      kind;
        logic       is_digit;
        logic [3:0] digit;
        logic       is_cr;
        logic       is_lf;
        logic       is_minus;
    } cls_t;

endpackage

// File: design/rrf_front.sv
// rrf_front: accepts request bytes and classifies them for the parser.
// Depends on rrf_pkg.
module rrf_front import rrf_pkg::*;
(
    input  logic in_valid,
    output logic in_ready,
    input  in_t  in_data,
    input  logic q_full,
    output logic q_push,
    output cls_t q_data
);

    logic [7:0] b;

    assign b        = in_data.data_byte;
    assign in_ready = !q_full;
    assign q_push   = in_valid && !q_full;

    always_comb
    begin
        q_data            = '0;
        q_data.data_byte  = b;
        q_data.last       = in_data.last_available;
        q_data.kind_valid = 1'b1;
        q_data.kind       = KIND_STRING;
        unique case (b)
            CH_PLUS:   q_data.kind = KIND_STRING;
            CH_MINUS:  q_data.kind = KIND_ERROR;
            CH_COLON:  q_data.kind = KIND_INTEGER;
            CH_DOLLAR: q_data.kind = KIND_BULK;
            CH_STAR:   q_data.kind = KIND_ARRAY;
            default:   q_data.kind_valid = 1'b0;
        endcase
        q_data.is_digit = (b >= CH_ZERO) && (b <= CH_NINE);
        q_data.digit    = 4'(b - CH_ZERO);
        q_data.is_cr    = (b == CH_CR);
        q_data.is_lf    = (b == CH_LF);
        q_data.is_minus = (b == CH_MINUS);
    end

endmodule

// File: design/rrf_queue.sv
// rrf_queue: short queue of classified bytes between front and back.
// Depends on rrf_pkg.
module rrf_queue import rrf_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cls_t push_data,
    output logic full,
    input  logic pop,
    output logic valid,
    output cls_t pop_data
);

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    cls_t          mem_reg [QUEUE_DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;

    assign full     = (count_reg == CW'(QUEUE_DEPTH));
    assign valid    = (count_reg != '0);
    assign pop_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// File: design/rrf_back.sv
// rrf_back: reply parser state machine, nesting stack and result register.
// Depends on rrf_pkg.
module rrf_back import rrf_pkg::*;
#(
    parameter int NEST_DEPTH = NEST_DEPTH_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic [31:0] max_bulk_length,
    input  logic [31:0] max_array_count,
    input  logic        q_valid,
    input  cls_t        q_data,
    output logic        q_pop,
    output logic        out_valid,
    input  logic        out_ready,
    output out_t        out_data
);

    localparam int LW = $clog2(NEST_DEPTH + 1);

    phase_t        phase_reg, phase_next;
    logic [LW-1:0] level_reg, level_next;
    logic [32:0]   num_reg, num_next;
    logic          neg_reg, neg_next;
    logic [31:0]   pay_reg, pay_next;
    logic [31:0]   cnt_reg, cnt_next;
    kind_t         kind_reg, kind_next;
    logic          out_valid_reg, out_valid_next;
    out_t          out_reg, out_next;

    logic [31:0]   stack_reg [NEST_DEPTH];
    logic [NEST_DEPTH-1:0] is_one;
    logic [LW-1:0] pop_level;
    logic          push_en;
    logic          pop_en;
    logic [36:0]   num_ext, num_acc;
    logic [32:0]   num_digit;
    status_t       err;
    logic          done;
    logic          frame_end;
    status_t       status;

    assign q_pop     = q_valid && (!out_valid_reg || out_ready);
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // Saturating decimal accumulate: value * 10 + digit.
    assign num_ext   = {4'b0, num_reg};
    assign num_acc   = (num_ext << 3) + (num_ext << 1) + 37'(q_data.digit);
    assign num_digit = (num_acc >= 37'(NUM_SAT)) ? NUM_SAT : num_acc[32:0];

    // Pop chain: the open level left after a completed element is one above
    // the highest open entry that does not hold exactly one element.
    always_comb
    begin
        pop_level = '0;
        for (int i = 0; i < NEST_DEPTH; i++)
        begin
            is_one[i] = (stack_reg[i] == 32'd1);
            if ((LW'(i) < level_reg) && !is_one[i])
            begin
                pop_level = LW'(i + 1);
            end
        end
    end

    always_comb
    begin
        phase_next     = phase_reg;
        level_next     = level_reg;
        num_next       = num_reg;
        neg_next       = neg_reg;
        pay_next       = pay_reg;
        cnt_next       = cnt_reg;
        kind_next      = kind_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        err            = ST_OK;
        done           = 1'b0;
        push_en        = 1'b0;
        pop_en         = 1'b0;
        frame_end      = 1'b0;
        status         = ST_OK;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        if (q_pop)
        begin
            if (phase_reg == PH_IDLE && level_reg == '0)
            begin
                cnt_next = 32'd1;
            end
            else if (cnt_reg != 32'hFFFF_FFFF)
            begin
                cnt_next = cnt_reg + 32'd1;
            end

            unique case (phase_reg)
                PH_IDLE:
                begin
                    if (!q_data.kind_valid)
                    begin
                        if (level_reg == '0)
                        begin
                            kind_next = KIND_STRING;
                        end
                        err = ST_PROTOCOL;
                    end
                    else
                    begin
                        if (level_reg == '0)
                        begin
                            kind_next = q_data.kind;
                        end
                        num_next = '0;
                        neg_next = 1'b0;
                        if (q_data.kind == KIND_BULK)
                        begin
                            phase_next = PH_BNUM_FIRST;
                        end
                        else if (q_data.kind == KIND_ARRAY)
                        begin
                            phase_next = PH_ANUM_FIRST;
                        end
                        else
                        begin
                            phase_next = PH_LINE;
                        end
                    end
                end
                PH_LINE:
                begin
                    if (q_data.is_cr)
                    begin
                        phase_next = PH_LINE_LF;
                    end
                end
                PH_LINE_LF, PH_PAY_LF:
                begin
                    if (q_data.is_lf)
                    begin
                        done = 1'b1;
                    end
                    else
                    begin
                        err = ST_PROTOCOL;
                    end
                end
                PH_BNUM_FIRST, PH_ANUM_FIRST:
                begin
                    if (q_data.is_minus && !neg_reg)
                    begin
                        neg_next = 1'b1;
                    end
                    else if (q_data.is_digit)
                    begin
                        num_next   = num_digit;
                        phase_next = (phase_reg == PH_BNUM_FIRST) ? PH_BNUM : PH_ANUM;
                    end
                    else
                    begin
                        err = ST_PROTOCOL;
                    end
                end
                PH_BNUM, PH_ANUM:
                begin
                    if (q_data.is_digit)
                    begin
                        num_next = num_digit;
                    end
                    else if (q_data.is_cr)
                    begin
                        phase_next = (phase_reg == PH_BNUM) ? PH_BNUM_LF : PH_ANUM_LF;
                    end
                    else
                    begin
                        err = ST_PROTOCOL;
                    end
                end
                PH_BNUM_LF:
                begin
                    if (!q_data.is_lf)
                    begin
                        err = ST_PROTOCOL;
                    end
                    else if (neg_reg && num_reg == 33'd1)
                    begin
                        done = 1'b1;
                    end
                    else if (neg_reg && num_reg != '0)
                    begin
                        err = ST_PROTOCOL;
                    end
                    else if (num_reg > {1'b0, max_bulk_length})
                    begin
                        err = ST_TOO_LARGE;
                    end
                    else
                    begin
                        pay_next   = num_reg[31:0];
                        phase_next = (num_reg[31:0] != '0) ? PH_PAYLOAD : PH_PAY_CR;
                    end
                end
                PH_PAYLOAD:
                begin
                    pay_next = pay_reg - 32'd1;
                    if (pay_reg == 32'd1)
                    begin
                        phase_next = PH_PAY_CR;
                    end
                end
                PH_PAY_CR:
                begin
                    if (q_data.is_cr)
                    begin
                        phase_next = PH_PAY_LF;
                    end
                    else
                    begin
                        err = ST_PROTOCOL;
                    end
                end
                PH_ANUM_LF:
                begin
                    if (!q_data.is_lf)
                    begin
                        err = ST_PROTOCOL;
                    end
                    else if (neg_reg)
                    begin
                        if (num_reg <= 33'd1)
                        begin
                            done = 1'b1;
                        end
                        else
                        begin
                            err = ST_PROTOCOL;
                        end
                    end
                    else if (num_reg > {1'b0, max_array_count})
                    begin
                        err = ST_TOO_LARGE;
                    end
                    else if (num_reg == '0)
                    begin
                        done = 1'b1;
                    end
                    else if (level_reg >= LW'(NEST_DEPTH))
                    begin
                        err = ST_NEST_OVER;
                    end
                    else
                    begin
                        push_en    = 1'b1;
                        level_next = level_reg + 1'b1;
                        phase_next = PH_IDLE;
                    end
                end
                default:
                begin
                    err = ST_PROTOCOL;
                end
            endcase

            if (err != ST_OK)
            begin
                phase_next = PH_IDLE;
                level_next = '0;
                status     = err;
            end
            else if (done)
            begin
                phase_next = PH_IDLE;
                pop_en     = 1'b1;
                level_next = pop_level;
                frame_end  = (pop_level == '0);
            end
            if (err == ST_OK && !frame_end && q_data.last)
            begin
                status = ST_INCOMPLETE;
            end

            out_valid_next       = 1'b1;
            out_next.frame_end   = frame_end;
            out_next.reply_kind  = kind_next;
            out_next.reply_bytes = cnt_next;
            out_next.status      = status;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            level_reg     <= '0;
            num_reg       <= '0;
            neg_reg       <= 1'b0;
            pay_reg       <= '0;
            cnt_reg       <= '0;
            kind_reg      <= KIND_STRING;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            level_reg     <= level_next;
            num_reg       <= num_next;
            neg_reg       <= neg_next;
            pay_reg       <= pay_next;
            cnt_reg       <= cnt_next;
            kind_reg      <= kind_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    // Each stack lane is written on a push at its level and decremented when
    // it is the entry left open by a completed element.
    for (genvar g = 0; g < NEST_DEPTH; g++)
    begin : g_lane
        always_ff @(posedge clk)
        begin
            if (push_en && level_reg == LW'(g))
            begin
                stack_reg[g] <= num_reg[31:0];
            end
            else if (pop_en && pop_level == LW'(g + 1))
            begin
                stack_reg[g] <= stack_reg[g] - 32'd1;
            end
        end
    end

endmodule

// File: design/resp_reply_framer_unit.sv
// resp_reply_framer_unit: top level of the reply framer.
// Depends on rrf_pkg, rrf_front, rrf_queue and rrf_back.
//
// The framer takes one byte of a reply stream per request and returns one
// result per byte: whether the byte completes a top-level reply, that reply's
// type, its byte count so far (saturating) and a status. Throughput is one
// byte per cycle unless the output stalls; a stalled output fills the queue
// and only then drops in_ready. A byte passes the two-entry queue between the
// classifier and the parser, then the result register. The rate is set by the
// parser state machine, which handles one byte per cycle, including the
// collapse of nested arrays done as a parallel compare over the nesting stack.
// The limit registers are written through cfg_we/cfg_index/cfg_data while
// no request is pending; the user must ensure this, the block does not.
module resp_reply_framer_unit import rrf_pkg::*;
#(
    parameter int NEST_DEPTH = NEST_DEPTH_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  in_t         in_data,
    output logic        out_valid,
    input  logic        out_ready,
    output out_t        out_data,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [31:0] cfg_data
);

    logic [31:0] max_bulk_reg;
    logic [31:0] max_array_reg;
    logic        q_full;
    logic        q_push;
    cls_t        q_in;
    logic        q_pop;
    logic        q_valid;
    cls_t        q_out;

    // Limit registers; an index that matches neither is ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_bulk_reg  <= 32'd536870912;
            max_array_reg <= 32'd1048576;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_MAX_BULK:  max_bulk_reg  <= cfg_data;
                CFG_MAX_ARRAY: max_array_reg <= cfg_data;
                default:       ;
            endcase
        end
    end

    rrf_front u_front (
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_data   (q_in)
    );

    rrf_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .valid     (q_valid),
        .pop_data  (q_out)
    );

    rrf_back #(
        .NEST_DEPTH (NEST_DEPTH)
    ) u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .max_bulk_length (max_bulk_reg),
        .max_array_count (max_array_reg),
        .q_valid         (q_valid),
        .q_data          (q_out),
        .q_pop           (q_pop),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .out_data        (out_data)
    );

endmodule

// File: design/rrf_checker.sv
// rrf_checker: port-level assertions for the reply framer, bound to the top.
// Depends on rrf_pkg and resp_reply_framer_unit.
module rrf_checker import rrf_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic out_valid,
    input logic out_ready,
    input out_t out_data
);

    // A held result keeps its contents.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result changed while stalled");

    // A completed reply never carries an error or incomplete status.
    a_end_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.frame_end |-> out_data.status == ST_OK)
        else $error("frame end with non-ok status");

    // Every result counts at least the byte that caused it.
    a_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.reply_bytes != 32'd0)
        else $error("zero byte count");

    // Reply kinds stay within the five defined types.
    a_kind: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.reply_kind <= 3'd4)
        else $error("undefined reply kind");

endmodule

bind resp_reply_framer_unit rrf_checker u_rrf_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);
